### sv/bpa_pkg.sv
package bpa_pkg;

	localparam int MAX_WORDS  = 64;
	localparam int WORD_BITS  = 64;
	localparam int PAGE_SHIFT = 12;
	localparam int ADDR_W     = 64;
	localparam int WIDX_W     = $clog2(MAX_WORDS);
	localparam int BIDX_W     = $clog2(WORD_BITS);
	localparam int NWORDS_W   = 7;
	localparam int PAGE_IDX_W = WIDX_W + BIDX_W;
	localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WORDS = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_OUTSIDE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_MODIFY
	} state_t;

	typedef struct packed {
		logic              en;
		logic [WIDX_W-1:0] idx;
		logic              full;
	} sum_upd_t;

	// index of the lowest clear bit of a bitmap word
	function automatic logic [BIDX_W-1:0] low_zero_bit(input logic [WORD_BITS-1:0] w);
		logic [BIDX_W-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r = i[BIDX_W-1:0];
			end
		end
		return r;
	endfunction

endpackage

### sv/bpa_ram.sv
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/bpa_summary.sv
module bpa_summary
	import bpa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [NWORDS_W-1:0] words_in_use,
	input  sum_upd_t            upd,
	input  logic [WIDX_W-1:0]   rd_idx,
	output logic                rd_valid,
	output logic                found,
	output logic [WIDX_W-1:0]   free_idx
);

	logic [MAX_WORDS-1:0] full_q;
	logic [MAX_WORDS-1:0] valid_q;
	logic [MAX_WORDS-1:0] cand;

	// per-word flags: written since reset, and every page taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= '0;
			valid_q <= '0;
		end else if (upd.en) begin
			full_q[upd.idx]  <= upd.full;
			valid_q[upd.idx] <= 1'b1;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_WORDS; i++) begin
			cand[i] = !full_q[i] && (NWORDS_W'(i) < words_in_use);
		end
		found    = |cand;
		free_idx = '0;
		for (int i = MAX_WORDS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				free_idx = i[WIDX_W-1:0];
			end
		end
	end

	assign rd_valid = valid_q[rd_idx];

endmodule

### sv/bitmap_page_allocator_core.sv
// first-fit 4 KiB page allocator over a bitmap memory of MAX_WORDS x WORD_BITS
// a request passes through three steps (accept, lookup, modify); modify waits while the result register is full
// a new request is accepted only once the last one has left modify, set by the bitmap ram read-modify-write
// result goes to an output register; the next request is taken while it waits
// reset clears both config registers and per-word valid/full flags; words never
// written read as all free, so no clearing pass is needed
module bitmap_page_allocator_core
	import bpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic [ADDR_W-1:0]    page_address,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ADDR_W-1:0]    alloc_address,
	output logic [STATUS_W-1:0]  status
);

	state_t               state_q, state_d;
	logic [ADDR_W-1:0]    base_q;
	logic [NWORDS_W-1:0]  words_q;
	logic [NWORDS_W-1:0]  n_words;
	logic                 op_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [WIDX_W-1:0]    widx_q;
	logic [BIDX_W-1:0]    bidx_q;
	logic                 act_q;
	logic                 wvalid_q;
	status_t              res_q;
	logic                 out_valid_q;
	logic [ADDR_W-1:0]    out_addr_q;
	status_t              out_status_q;

	logic                 found;
	logic [WIDX_W-1:0]    free_idx;
	logic                 rd_valid;
	logic [ADDR_W:0]      offset;
	logic [PAGE_W-1:0]    page;
	logic [PAGE_W-1:0]    limit;
	logic                 outside;
	logic                 rd_en;
	logic [WIDX_W-1:0]    rd_idx;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] cur_word;
	logic [WORD_BITS-1:0] new_word;
	logic [BIDX_W-1:0]    bit_idx;
	logic [PAGE_IDX_W-1:0] page_idx;
	logic                 slot_free;
	logic                 finish;
	logic                 wr_en;
	sum_upd_t             upd;

	assign n_words = (words_q > NWORDS_W'(MAX_WORDS)) ? NWORDS_W'(MAX_WORDS) : words_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			words_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE:  base_q  <= cfg_data;
				REG_WORDS: words_q <= cfg_data[NWORDS_W-1:0];
				default:   ;
			endcase
		end
	end

	// free range check
	assign offset  = {1'b0, addr_q} - {1'b0, base_q};
	assign page    = offset[ADDR_W-1:PAGE_SHIFT];
	assign limit   = PAGE_W'({n_words, {BIDX_W{1'b0}}});
	assign outside = offset[ADDR_W] || (page >= limit);

	assign rd_en  = (state_q == ST_LOOKUP);
	assign rd_idx = (op_q == OP_ALLOC) ? free_idx : page[PAGE_IDX_W-1:BIDX_W];

	bpa_summary u_summary (
		.clk          (clk),
		.arst_n       (arst_n),
		.words_in_use (n_words),
		.upd          (upd),
		.rd_idx       (rd_idx),
		.rd_valid     (rd_valid),
		.found        (found),
		.free_idx     (free_idx)
	);

	bpa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAX_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (wr_en),
		.waddr (widx_q),
		.wdata (new_word),
		.re    (rd_en),
		.raddr (rd_idx),
		.rdata (rd_word)
	);

	// modify stage
	assign cur_word  = wvalid_q ? rd_word : '0;
	assign bit_idx   = (op_q == OP_ALLOC) ? low_zero_bit(cur_word) : bidx_q;
	assign new_word  = (op_q == OP_ALLOC) ? (cur_word | (WORD_BITS'(1) << bit_idx))
	                                      : (cur_word & ~(WORD_BITS'(1) << bit_idx));
	assign page_idx  = {widx_q, bit_idx};
	assign slot_free = !out_valid_q || out_ready;
	assign finish    = (state_q == ST_MODIFY) && slot_free;
	assign wr_en     = finish && act_q;

	always_comb begin
		upd.en   = wr_en;
		upd.idx  = widx_q;
		upd.full = &new_word;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = ST_MODIFY;
			end
			ST_MODIFY: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= opcode;
			addr_q <= page_address;
		end
		if (state_q == ST_LOOKUP) begin
			widx_q   <= rd_idx;
			bidx_q   <= page[BIDX_W-1:0];
			wvalid_q <= rd_valid;
			if (op_q == OP_ALLOC) begin
				act_q <= found;
				res_q <= found ? STAT_OK : STAT_FULL;
			end else begin
				act_q <= !outside;
				res_q <= outside ? STAT_OUTSIDE : STAT_OK;
			end
		end
		if (finish) begin
			out_status_q <= res_q;
			if (op_q == OP_ALLOC && act_q) begin
				out_addr_q <= base_q + (ADDR_W'(page_idx) << PAGE_SHIFT);
			end else begin
				out_addr_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign alloc_address = out_addr_q;
	assign status        = out_status_q;

endmodule
